/* rtl/assert_macros.svh */
// assertion macros shared by the ramp generator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, masked while rst_n is low
`define CHK_ON_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// concurrent check on clk that also holds during reset
`define CHK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/stpramp_pkg.sv */
// shared types and constants of the trapezoidal stepper ramp generator
package stpramp_pkg;

  // fixed field widths
  localparam int PERIOD_W   = 16;
  localparam int TARGET_W   = 32;
  localparam int POS_W      = 32;
  localparam int RAMP_W     = 32;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_USED_W = 51;
  localparam int OUT_DATA_W = 56;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // parameter defaults
  localparam int DEF_FRAC_BITS = 8;
  localparam int DEF_POS_BITS  = 32;

  // register reset values
  localparam logic [PERIOD_W-1:0] START_PERIOD_RST = 16'd1600;
  localparam logic [PERIOD_W-1:0] MIN_PERIOD_RST   = 16'd20;

  // configuration register indexes
  localparam int CFG_ADDR_W = 1;
  localparam logic [CFG_ADDR_W-1:0] REG_START_PERIOD = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_PERIOD   = 1'b1;

  // input item kinds
  localparam logic MODE_MOVE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_MDIFF,
    S_MABS,
    S_STEP,
    S_RSEL,
    S_DCHK,
    S_DLOAD,
    S_DWAIT,
    S_DAPPLY,
    S_EMIT
  } state_t;

endpackage

/* rtl/stpramp_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module stpramp_div #(
  parameter int DVD_W = 25,
  parameter int DVS_W = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CW    = (DVD_W + 1 > DVS_W) ? DVD_W + 1 : DVS_W;
  localparam int CNT_W = $clog2(DVD_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(DVD_W - 1);

  logic [DVD_W-2:0] rem_r, rem_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;

  logic [DVD_W-1:0] trial;
  logic [CW-1:0]    trial_ext;
  logic [CW-1:0]    dvs_ext;
  logic [CW-1:0]    diff;
  logic             ge;

  // one trial subtraction: partial remainder shifted with the next dividend bit
  always_comb begin
    trial     = {rem_r, quo_r[DVD_W-1]};
    trial_ext = CW'(trial);
    dvs_ext   = CW'(dvs_r);
    diff      = trial_ext - dvs_ext;
    ge        = (trial_ext >= dvs_ext);
  end

  // load on start, then shift one bit a cycle
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = busy_r && (cnt_r == LAST);
    if (start && !busy_r) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DVD_W-2:0] : trial[DVD_W-2:0];
      quo_nxt = {quo_r[DVD_W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // shift registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* rtl/stepper_trapezoid_ramp.sv */
// top level of the trapezoidal stepper ramp generator
//
//  channel | direction | beat contents
//  in_*    | slave     | tuser: mode; tdata: target
//  out_*   | master    | tdata: step_pulse, direction, period, position, move_done
//  cfg_*   | write     | cfg_addr selects start_period or min_period
//
// a move beat runs MDIFF and MABS, an idle tick goes straight to EMIT, a cruising
// tick runs STEP, RSEL and DCHK, a ramping tick (DCHK too when slowing) runs the
// bit-serial divider, one quotient bit per cycle over the 17 + FRAC_BITS bit doubled delay
// rst_n is synchronous; reset leaves the block idle with move_done high
// a result waits in the output register; a new beat is taken meanwhile, and
// the sequencer holds in its emit state only while that register is still full
`include "assert_macros.svh"

module stepper_trapezoid_ramp #(
  parameter int FRAC_BITS = stpramp_pkg::DEF_FRAC_BITS,
  parameter int POS_BITS  = stpramp_pkg::DEF_POS_BITS
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // tdata: target [31:0]
  input  logic [stpramp_pkg::IN_DATA_W-1:0]      in_tdata,
  // tuser: mode [0]
  input  logic                                   in_tuser,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // tdata: step_pulse [0], direction [1], period [17:2], position [49:18],
  // move_done [50], zero fill [55:51]
  output logic [stpramp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  input  logic                                   cfg_we,
  input  logic [stpramp_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [stpramp_pkg::PERIOD_W-1:0]       cfg_wdata
);

  localparam int DW    = stpramp_pkg::PERIOD_W + FRAC_BITS;
  localparam int DVD_W = DW + 1;
  localparam int DVS_W = stpramp_pkg::RAMP_W + 2;
  localparam logic [DW-1:0] DELAY_MAX = '1;

  stpramp_pkg::state_t state_r, state_nxt;

  // configuration
  logic [stpramp_pkg::PERIOD_W-1:0] start_period_r, min_period_r;

  // motion state
  logic [POS_BITS-1:0]            cur_position_r, cur_position_nxt;
  logic [POS_BITS-1:0]            total_steps_r, total_steps_nxt;
  logic [POS_BITS-1:0]            steps_issued_r, steps_issued_nxt;
  logic [POS_BITS-1:0]            ramp_up_r, ramp_up_nxt;
  logic [stpramp_pkg::RAMP_W-1:0] ramp_index_r, ramp_index_nxt;
  logic [DW-1:0]                  delay_r, delay_nxt;
  logic                           dir_r, dir_nxt;
  logic                           done_r, done_nxt;

  // per-beat working registers
  logic [POS_BITS-1:0] target_r, target_nxt;
  logic [POS_BITS:0]   diff_r, diff_nxt;
  logic [POS_BITS-1:0] thr_r, thr_nxt;
  logic                accel_r, accel_nxt;
  logic                pulse_r, pulse_nxt;

  // output register
  logic [stpramp_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic                               out_tvalid_r, out_tvalid_nxt;

  // sequencer outputs
  logic in_accept;
  logic out_free;
  logic out_load;
  logic div_start;

  // divider
  logic             div_busy;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_dvs;

  // datapath helpers
  logic [POS_BITS:0]              tgt_ext, cur_ext, diff_neg;
  logic [DW-1:0]                  min_fixed;
  logic [DVD_W-1:0]               d_sub;
  logic [DW+1:0]                  d_sum;
  logic [stpramp_pkg::POS_W-1:0]  pos_out;

  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      stpramp_pkg::S_IDLE: begin
        if (in_accept) begin
          if (in_tuser == stpramp_pkg::MODE_MOVE) begin
            state_nxt = stpramp_pkg::S_MDIFF;
          end else if (done_r) begin
            state_nxt = stpramp_pkg::S_EMIT;
          end else begin
            state_nxt = stpramp_pkg::S_STEP;
          end
        end
      end
      stpramp_pkg::S_MDIFF:  state_nxt = stpramp_pkg::S_MABS;
      stpramp_pkg::S_MABS:   state_nxt = stpramp_pkg::S_EMIT;
      stpramp_pkg::S_STEP:   state_nxt = stpramp_pkg::S_RSEL;
      stpramp_pkg::S_RSEL: begin
        state_nxt = (ramp_up_r == '0) ? stpramp_pkg::S_DLOAD : stpramp_pkg::S_DCHK;
      end
      stpramp_pkg::S_DCHK: begin
        state_nxt = (steps_issued_r >= thr_r) ? stpramp_pkg::S_DLOAD : stpramp_pkg::S_EMIT;
      end
      stpramp_pkg::S_DLOAD:  state_nxt = stpramp_pkg::S_DWAIT;
      stpramp_pkg::S_DWAIT: begin
        if (div_done) begin
          state_nxt = stpramp_pkg::S_DAPPLY;
        end
      end
      stpramp_pkg::S_DAPPLY: state_nxt = stpramp_pkg::S_EMIT;
      stpramp_pkg::S_EMIT: begin
        if (out_free) begin
          state_nxt = stpramp_pkg::S_IDLE;
        end
      end
      default:               state_nxt = stpramp_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state_r)
      stpramp_pkg::S_IDLE:  in_tready = 1'b1;
      stpramp_pkg::S_DLOAD: div_start = 1'b1;
      stpramp_pkg::S_EMIT:  out_load  = out_free;
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // datapath helpers
  always_comb begin
    tgt_ext   = (POS_BITS + 1)'($signed(target_r));
    cur_ext   = (POS_BITS + 1)'($signed(cur_position_r));
    diff_neg  = -diff_r;
    min_fixed = {min_period_r, FRAC_BITS'(0)};
    d_sub     = {1'b0, delay_r} - div_quo;
    d_sum     = {2'b00, delay_r} + (DW + 2)'(div_quo);
    pos_out   = stpramp_pkg::POS_W'($signed(cur_position_r));
  end

  // divisor: 4n+1 while speeding up, 4n-1 while slowing down
  assign div_dvs = accel_r ? {ramp_index_r, 2'b01} : {ramp_index_r - 1'b1, 2'b11};

  // per-state register updates
  always_comb begin
    cur_position_nxt = cur_position_r;
    total_steps_nxt  = total_steps_r;
    steps_issued_nxt = steps_issued_r;
    ramp_up_nxt      = ramp_up_r;
    ramp_index_nxt   = ramp_index_r;
    delay_nxt        = delay_r;
    dir_nxt          = dir_r;
    done_nxt         = done_r;
    target_nxt       = target_r;
    diff_nxt         = diff_r;
    thr_nxt          = thr_r;
    accel_nxt        = accel_r;
    pulse_nxt        = pulse_r;
    case (state_r)
      stpramp_pkg::S_IDLE: begin
        if (in_accept) begin
          target_nxt = in_tdata[POS_BITS-1:0];
          pulse_nxt  = 1'b0;
        end
      end
      // signed distance from the current position
      stpramp_pkg::S_MDIFF: begin
        diff_nxt = tgt_ext - cur_ext;
      end
      // new move: direction, step total and start period
      stpramp_pkg::S_MABS: begin
        dir_nxt          = diff_r[POS_BITS];
        total_steps_nxt  = diff_r[POS_BITS] ? diff_neg[POS_BITS-1:0] : diff_r[POS_BITS-1:0];
        delay_nxt        = {start_period_r, FRAC_BITS'(0)};
        steps_issued_nxt = '0;
        ramp_index_nxt   = '0;
        ramp_up_nxt      = '0;
        done_nxt         = 1'b0;
      end
      // issue a step or finish the move
      stpramp_pkg::S_STEP: begin
        if (steps_issued_r < total_steps_r) begin
          pulse_nxt        = 1'b1;
          steps_issued_nxt = steps_issued_r + 1'b1;
          cur_position_nxt = dir_r ? cur_position_r - 1'b1 : cur_position_r + 1'b1;
        end else begin
          done_nxt = 1'b1;
        end
      end
      // pick the ramp phase
      stpramp_pkg::S_RSEL: begin
        if (ramp_up_r == '0) begin
          accel_nxt = 1'b1;
          if (ramp_index_r != '1) begin
            ramp_index_nxt = ramp_index_r + 1'b1;
          end
        end else begin
          thr_nxt = total_steps_r - ramp_up_r;
        end
      end
      // slowing down: step the index back, never below one
      stpramp_pkg::S_DCHK: begin
        if (steps_issued_r >= thr_r) begin
          accel_nxt      = 1'b0;
          ramp_index_nxt = (ramp_index_r > stpramp_pkg::RAMP_W'(1)) ?
                           ramp_index_r - 1'b1 : stpramp_pkg::RAMP_W'(1);
        end
      end
      // apply the quotient to the delay
      stpramp_pkg::S_DAPPLY: begin
        if (accel_r) begin
          delay_nxt = d_sub[DW-1:0];
          if (d_sub[DW-1:0] <= min_fixed) begin
            delay_nxt = min_fixed;
          end
          if ((d_sub[DW-1:0] <= min_fixed) || (steps_issued_r >= (total_steps_r >> 1))) begin
            ramp_up_nxt = steps_issued_r;
          end
        end else begin
          delay_nxt = (d_sum[DW+1:DW] != 2'b00) ? DELAY_MAX : d_sum[DW-1:0];
        end
      end
      default: ;
    endcase
  end

  // result beat
  always_comb begin
    out_data_nxt   = out_data_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    if (out_load) begin
      out_data_nxt   = {stpramp_pkg::OUT_PAD_W'(0), done_r, pos_out,
                        delay_r[DW-1:FRAC_BITS], dir_r, pulse_r};
      out_tvalid_nxt = 1'b1;
    end
  end

  // control and motion state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= stpramp_pkg::S_IDLE;
      start_period_r <= stpramp_pkg::START_PERIOD_RST;
      min_period_r   <= stpramp_pkg::MIN_PERIOD_RST;
      cur_position_r <= '0;
      total_steps_r  <= '0;
      steps_issued_r <= '0;
      ramp_up_r      <= '0;
      ramp_index_r   <= '0;
      delay_r        <= '0;
      dir_r          <= 1'b0;
      done_r         <= 1'b1;
      out_tvalid_r   <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cur_position_r <= cur_position_nxt;
      total_steps_r  <= total_steps_nxt;
      steps_issued_r <= steps_issued_nxt;
      ramp_up_r      <= ramp_up_nxt;
      ramp_index_r   <= ramp_index_nxt;
      delay_r        <= delay_nxt;
      dir_r          <= dir_nxt;
      done_r         <= done_nxt;
      out_tvalid_r   <= out_tvalid_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          stpramp_pkg::REG_START_PERIOD: start_period_r <= cfg_wdata;
          stpramp_pkg::REG_MIN_PERIOD:   min_period_r   <= cfg_wdata;
          default: begin
            start_period_r <= start_period_r;
          end
        endcase
      end
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    target_r   <= target_nxt;
    diff_r     <= diff_nxt;
    thr_r      <= thr_nxt;
    accel_r    <= accel_nxt;
    pulse_r    <= pulse_nxt;
    out_data_r <= out_data_nxt;
  end

  // bit-serial divider for 2d / (4n +- 1)
  stpramp_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({delay_r, 1'b0}),
    .divisor  (div_dvs),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  assign out_tdata  = out_data_r;
  assign out_tvalid = out_tvalid_r;

  // checks
  `CHK_ON_CLK(a_issued_le_total, steps_issued_r <= total_steps_r, "steps issued exceed total")
  `CHK_ON_CLK(a_index_nonzero, div_start |-> (ramp_index_r != '0), "zero ramp index")
  `CHK_ON_CLK(a_div_start_free, div_start |-> !div_busy, "divider started while busy")
  `CHK_ON_CLK(a_out_from_emit, $rose(out_tvalid_r) |-> $past(out_load), "beat outside emit")

endmodule
